// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the moving average block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RMA_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define RMA_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rma_pkg.sv
// Shared types and fixed widths of the moving average block
package rma_pkg;

	// item field widths
	localparam int SAMPLE_W  = 12;
	localparam int AVG_W     = 16;
	localparam int FILL_W    = 5;
	localparam int FRAC_W    = 4;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;

	// divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// File: rtl/ramping_moving_average_core.sv
// Top level: moving average sequencer, sum and count, output register
//
// channel | dir | tdata bits                                   | tuser
// s_axis  | in  | [11:0] sample, [15:12] zero                  | [0] clear
// m_axis  | out | [15:0] average_q4, [20:16] fill_count,       | none
//         |     | [21] is_full, [23:22] zero                   |
//
// A sample item runs, from accept to next accept, through one update step, one divider
// load, NUM_W = 16 + clog2(DEPTH) bit-serial divide steps, one quotient latch and one
// output register load; that load waits while a held result is not yet taken by m_tready.
// A clear resets index, count and sum and goes straight to the output register load.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register, so the next item is taken while it waits.
// arst_n clears index, count, sum and flags; ring contents are left as they are.
module ramping_moving_average_core #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rma_pkg::S_TDATA_W-1:0] s_tdata,  // [11:0] sample, rest zero
	input  logic                          s_tuser,  // [0] clear
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rma_pkg::M_TDATA_W-1:0] m_tdata   // [15:0] avg, [20:16] fill, [21] full
);

	`include "assert_macros.svh"

	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SW    = rma_pkg::SAMPLE_W + $clog2(DEPTH);
	localparam int NUM_W = SW + rma_pkg::FRAC_W;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                    state_q;
	logic [IW-1:0]                 idx_q;
	logic [CW-1:0]                 count_q;
	logic [SW-1:0]                 sum_q;
	logic [rma_pkg::SAMPLE_W-1:0]  sample_q;
	logic [rma_pkg::AVG_W-1:0]     avg_q;
	logic                          out_valid_q;
	logic [rma_pkg::M_TDATA_W-1:0] out_data_q;
	logic                          div_go_q;

	logic                          in_acc;
	logic                          full;
	logic [rma_pkg::SAMPLE_W-1:0]  old_sample;
	logic [SW-1:0]                 sum_next;
	logic [CW-1:0]                 count_next;
	logic                          ring_we;
	logic                          div_start;
	rma_pkg::div_status_t          div_st;
	logic [NUM_W-1:0]              quotient;
	logic                          out_load;
	logic [rma_pkg::FILL_W+CW-1:0] fill_ext;

	assign in_acc = s_tvalid && s_tready;
	assign full   = (count_q == CW'(DEPTH));

	// sample ring
	rma_ring #(
		.DEPTH(DEPTH),
		.AW   (IW)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(idx_q),
		.wdata(sample_q),
		.raddr(idx_q),
		.rdata(old_sample)
	);

	// divider: sum * 16 / count
	rma_divider #(
		.NUM_W(NUM_W),
		.DEN_W(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({sum_q, {rma_pkg::FRAC_W{1'b0}}}),
		.divisor (count_q),
		.status  (div_st),
		.quotient(quotient)
	);

	// drop the oldest sample once full, add the new one
	assign sum_next   = sum_q - (full ? SW'(old_sample) : SW'(0)) + SW'(sample_q);
	assign count_next = full ? count_q : count_q + 1'b1;
	assign ring_we    = (state_q == ST_UPD);
	// start the divider in the first divide cycle, once sum and count are updated
	assign div_start  = div_go_q && !div_st.busy;
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	// sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= (state_q == ST_UPD);
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser) begin
							idx_q   <= '0;
							count_q <= '0;
							sum_q   <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					sum_q   <= sum_next;
					count_q <= count_next;
					idx_q   <= (idx_q == IW'(DEPTH - 1)) ? '0 : idx_q + 1'b1;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and average holding registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= s_tdata[rma_pkg::SAMPLE_W-1:0];
			avg_q    <= '0;
		end else if (div_st.done) begin
			avg_q <= quotient[rma_pkg::AVG_W-1:0];
		end
	end

	// output register
	assign fill_ext = {{rma_pkg::FILL_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {2'b00, full, fill_ext[rma_pkg::FILL_W-1:0], avg_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// checks
	`RMA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "fill count above depth")
	`RMA_ASSERT_IMP(a_div_in_state, clk, arst_n, div_st.done, state_q == ST_DIV, "divider done outside divide state")
	`RMA_ASSERT_NXT(a_clear_empties, clk, arst_n, in_acc && s_tuser, count_q == '0 && sum_q == '0 && state_q == ST_OUT, "clear left state behind")

endmodule

// File: rtl/rma_ring.sv
// Sample ring storage: one write port, one registered read port
module rma_ring #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [rma_pkg::SAMPLE_W-1:0] wdata,
	input  logic [AW-1:0]                raddr,
	output logic [rma_pkg::SAMPLE_W-1:0] rdata
);

	logic [rma_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
	logic [rma_pkg::SAMPLE_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/rma_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle
module rma_divider #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     dividend,
	input  logic [DEN_W-1:0]     divisor,
	output rma_pkg::div_status_t status,
	output logic [NUM_W-1:0]     quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = num_q;

endmodule
